>>> design/tsni_pkg.sv
`timescale 1ns / 1ps

package tsni_pkg;

    localparam int MAX_PACKET  = 16384;
    localparam int SESSION_POS = 43;
    localparam int N_METHODS   = 5;

    localparam logic [7:0] REC_HANDSHAKE = 8'h16;
    localparam logic [7:0] REC_MAJOR     = 8'h03;
    localparam logic [7:0] REC_MINOR_MAX = 8'h04;
    localparam logic [7:0] HS_CLIENT_HELLO = 8'h01;

    localparam logic [7:0] METHOD_TEXT [N_METHODS][8] = '{
        '{8'h47, 8'h45, 8'h54, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h50, 8'h4F, 8'h53, 8'h54, 8'h20, 8'h00, 8'h00, 8'h00},
        '{8'h48, 8'h45, 8'h41, 8'h44, 8'h20, 8'h00, 8'h00, 8'h00},
        '{8'h50, 8'h55, 8'h54, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h43, 8'h4F, 8'h4E, 8'h4E, 8'h45, 8'h43, 8'h54, 8'h20}
    };
    localparam logic [3:0] METHOD_LEN [N_METHODS] = '{4'd4, 4'd5, 4'd5, 4'd4, 4'd8};

    typedef enum logic [4:0] {
        PH_SESSION,
        PH_CIPH_HI,
        PH_CIPH_LO,
        PH_COMP,
        PH_EXTLEN_HI,
        PH_EXTLEN_LO,
        PH_EXT_T0,
        PH_EXT_T1_Z,
        PH_EXT_T1_N,
        PH_EXT_L0_S,
        PH_EXT_L1_S,
        PH_EXT_L0_O,
        PH_EXT_L1_O,
        PH_SNI_TYPE,
        PH_SNI_N0,
        PH_SNI_N1,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic        tls_hello_seen;
        logic        http_request_seen;
        logic        sni_found;
        logic [14:0] name_offset;
        logic [15:0] sni_length;
        logic [13:0] split_position;
        logic [14:0] packet_length;
        logic        overlong;
    } t_out_item;

endpackage

>>> design/tsni_parser.sv
`timescale 1ns / 1ps

module tsni_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  tsni_pkg::t_in_item i_item,
    input  logic [13:0]        i_split_cfg,
    output tsni_pkg::t_out_item o_result
);
    import tsni_pkg::*;

    logic [14:0] r_pos,       n_pos;
    t_phase      r_phase,     n_phase;
    logic [14:0] r_next_pos,  n_next_pos;
    logic [16:0] r_ext_end,   n_ext_end;
    logic [15:0] r_acc,       n_acc;
    logic [3:0]  r_hdr_ok,    n_hdr_ok;
    logic [4:0]  r_meth,      n_meth;
    logic        r_found,     n_found;
    logic [14:0] r_found_off, n_found_off;
    logic [15:0] r_found_len, n_found_len;
    logic        r_over,      n_over;

    logic [13:0] pos;
    logic [7:0]  b;
    logic [15:0] v;
    logic [17:0] tgt;
    t_phase      tgt_ph;
    logic        go;
    logic        ext_chk;

    assign pos = r_pos[13:0];
    assign b   = i_item.payload_byte;
    assign v   = {r_acc[7:0], b};

    // per-byte field walk
    always_comb begin
        n_pos       = r_pos;
        n_phase     = r_phase;
        n_next_pos  = r_next_pos;
        n_ext_end   = r_ext_end;
        n_acc       = r_acc;
        n_hdr_ok    = r_hdr_ok;
        n_meth      = r_meth;
        n_found     = r_found;
        n_found_off = r_found_off;
        n_found_len = r_found_len;
        n_over      = r_over;
        tgt         = '0;
        tgt_ph      = r_phase;
        go          = 1'b0;
        ext_chk     = 1'b0;
        if (r_pos == 15'(MAX_PACKET)) begin
            n_over = 1'b1;
        end else begin
            n_pos = r_pos + 15'd1;
            if (pos == 14'd0 && b != REC_HANDSHAKE)  n_hdr_ok[0] = 1'b0;
            if (pos == 14'd1 && b != REC_MAJOR)      n_hdr_ok[1] = 1'b0;
            if (pos == 14'd2 && b > REC_MINOR_MAX)   n_hdr_ok[2] = 1'b0;
            if (pos == 14'd5 && b != HS_CLIENT_HELLO) n_hdr_ok[3] = 1'b0;
            for (int m = 0; m < N_METHODS; m++) begin
                if (r_pos < 15'(METHOD_LEN[m]) && b != METHOD_TEXT[m][r_pos[2:0]])
                    n_meth[m] = 1'b0;
            end
            if (r_phase == PH_SNI_N1) begin
                if ({1'b0, pos} == r_next_pos) begin
                    n_found_len = v;
                    n_found     = 1'b1;
                    n_phase     = PH_DONE;
                end
            end else if (r_phase == PH_SESSION) begin
                if (pos == 14'(SESSION_POS)) begin
                    go     = 1'b1;
                    tgt    = 18'(pos) + 18'd1 + 18'(b);
                    tgt_ph = PH_CIPH_HI;
                end
            end else if (r_phase != PH_DONE && {1'b0, pos} == r_next_pos) begin
                case (r_phase)
                    PH_CIPH_HI: begin
                        n_acc = {8'd0, b};
                        go = 1'b1; tgt = 18'(pos) + 18'd1; tgt_ph = PH_CIPH_LO;
                    end
                    PH_CIPH_LO: begin
                        go = 1'b1; tgt = 18'(pos) + 18'd1 + 18'(v); tgt_ph = PH_COMP;
                    end
                    PH_COMP: begin
                        go = 1'b1; tgt = 18'(pos) + 18'd1 + 18'(b); tgt_ph = PH_EXTLEN_HI;
                    end
                    PH_EXTLEN_HI: begin
                        n_acc = {8'd0, b};
                        go = 1'b1; tgt = 18'(pos) + 18'd1; tgt_ph = PH_EXTLEN_LO;
                    end
                    PH_EXTLEN_LO: begin
                        n_ext_end = 17'(17'(pos) + 17'd1 + 17'(v));
                        go = 1'b1; ext_chk = 1'b1;
                        tgt = 18'(pos) + 18'd1; tgt_ph = PH_EXT_T0;
                    end
                    PH_EXT_T0: begin
                        go = 1'b1; tgt = 18'(pos) + 18'd1;
                        tgt_ph = (b == 8'd0) ? PH_EXT_T1_Z : PH_EXT_T1_N;
                    end
                    PH_EXT_T1_Z: begin
                        go = 1'b1; tgt = 18'(pos) + 18'd1;
                        tgt_ph = (b == 8'd0) ? PH_EXT_L0_S : PH_EXT_L0_O;
                    end
                    PH_EXT_T1_N: begin
                        go = 1'b1; tgt = 18'(pos) + 18'd1; tgt_ph = PH_EXT_L0_O;
                    end
                    PH_EXT_L0_S: begin
                        n_acc = {8'd0, b};
                        go = 1'b1; tgt = 18'(pos) + 18'd1; tgt_ph = PH_EXT_L1_S;
                    end
                    PH_EXT_L0_O: begin
                        n_acc = {8'd0, b};
                        go = 1'b1; tgt = 18'(pos) + 18'd1; tgt_ph = PH_EXT_L1_O;
                    end
                    PH_EXT_L1_O: begin
                        go = 1'b1; ext_chk = 1'b1;
                        tgt = 18'(pos) + 18'd1 + 18'(v); tgt_ph = PH_EXT_T0;
                    end
                    PH_EXT_L1_S: begin
                        n_acc = v;
                        go = 1'b1;
                        if (v >= 16'd5 && 18'(pos) + 18'd6 <= 18'(r_ext_end)) begin
                            tgt = 18'(pos) + 18'd3; tgt_ph = PH_SNI_TYPE;
                        end else begin
                            ext_chk = 1'b1;
                            tgt = 18'(pos) + 18'd1 + 18'(v); tgt_ph = PH_EXT_T0;
                        end
                    end
                    PH_SNI_TYPE: begin
                        go = 1'b1;
                        if (b == 8'd0) begin
                            n_found_off = 15'(pos) + 15'd3;
                            tgt = 18'(pos) + 18'd1; tgt_ph = PH_SNI_N0;
                        end else begin
                            ext_chk = 1'b1;
                            tgt = 18'(pos) + 18'(r_acc) - 18'd2; tgt_ph = PH_EXT_T0;
                        end
                    end
                    PH_SNI_N0: begin
                        n_acc      = {8'd0, b};
                        n_next_pos = 15'(pos) + 15'd1;
                        n_phase    = PH_SNI_N1;
                    end
                    default: begin
                    end
                endcase
            end
            if (go) begin
                if (ext_chk && tgt + 18'd4 > 18'(n_ext_end)) begin
                    n_phase = PH_DONE;
                end else if (tgt >= 18'(MAX_PACKET)) begin
                    n_phase = PH_DONE;
                end else begin
                    n_next_pos = tgt[14:0];
                    n_phase    = tgt_ph;
                end
            end
        end
    end

    logic        res_tls;
    logic        res_sni;
    logic [15:0] off_plus;
    logic [15:0] split_pick;

    // result for the packet ending with this byte
    always_comb begin
        res_tls  = (n_pos >= 15'd9) && (n_hdr_ok == 4'hF);
        res_sni  = res_tls && n_found;
        off_plus = 16'(n_found_off) + 16'd1;
        if (i_split_cfg != 14'd0 && 15'(i_split_cfg) < n_pos)
            split_pick = 16'(i_split_cfg);
        else if (res_sni && off_plus < 16'(n_pos))
            split_pick = off_plus;
        else
            split_pick = 16'd2;
        if (split_pick >= 16'(n_pos))
            split_pick = 16'd1;
        o_result.tls_hello_seen    = res_tls;
        o_result.http_request_seen = (n_pos >= 15'd10) && (n_meth != 5'd0);
        o_result.sni_found         = res_sni;
        o_result.name_offset       = res_sni ? n_found_off : 15'd0;
        o_result.sni_length        = res_sni ? n_found_len : 16'd0;
        o_result.split_position    = split_pick[13:0];
        o_result.packet_length     = n_pos;
        o_result.overlong          = n_over;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_item.last_byte)) begin
            r_pos       <= '0;
            r_phase     <= PH_SESSION;
            r_next_pos  <= '0;
            r_ext_end   <= '0;
            r_acc       <= '0;
            r_hdr_ok    <= 4'hF;
            r_meth      <= 5'h1F;
            r_found     <= 1'b0;
            r_found_off <= '0;
            r_found_len <= '0;
            r_over      <= 1'b0;
        end else if (i_step) begin
            r_pos       <= n_pos;
            r_phase     <= n_phase;
            r_next_pos  <= n_next_pos;
            r_ext_end   <= n_ext_end;
            r_acc       <= n_acc;
            r_hdr_ok    <= n_hdr_ok;
            r_meth      <= n_meth;
            r_found     <= n_found;
            r_found_off <= n_found_off;
            r_found_len <= n_found_len;
            r_over      <= n_over;
        end
    end

endmodule

>>> design/tls_sni_locator_and_split_point_core.sv
`timescale 1ns / 1ps

// ClientHello / HTTP classifier with SNI locator and first-segment split point.
// Input channel: one payload byte per transaction (i_in_valid / o_in_stall),
// last_byte marks the end of the packet. Output channel (o_out_valid /
// i_out_stall): one result transaction per packet, issued for its last byte.
// Config channel (i_cfg_valid / o_cfg_ready): forced split offset, always
// ready; write it only while no packet is in flight.
// Throughput: one byte per cycle, set by the single-pass byte parser between
// the input register and the result register, except that a last byte waits
// while the previous result is still held by a stall. A result is written
// to the result register as its last byte leaves the input register.
// Stall: a held result does not block bytes in the middle of a packet; only a
// second last byte waits in the input register, which then raises o_in_stall.
// Reset (synchronous, active low) clears the parser, the valid flags of both
// pipeline registers and the split offset. Bytes past 16384 per packet are
// dropped and reported through the overlong flag.
module tls_sni_locator_and_split_point_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tsni_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tsni_pkg::t_out_item o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [13:0]         i_cfg_data
);
    import tsni_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_data;
    logic [13:0] r_split_cfg;

    logic      out_free;
    logic      adv;
    logic      accept;
    t_out_item result;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign adv         = r_in_valid && (!r_in_item.last_byte || out_free);
    assign o_in_stall  = r_in_valid && !adv;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    tsni_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (adv),
        .i_item      (r_in_item),
        .i_split_cfg (r_split_cfg),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_split_cfg <= '0;
        end else begin
            if (accept)
                r_in_valid <= 1'b1;
            else if (adv)
                r_in_valid <= 1'b0;
            if (adv && r_in_item.last_byte)
                r_out_valid <= 1'b1;
            else if (!i_out_stall)
                r_out_valid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready)
                r_split_cfg <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept)
            r_in_item <= i_in_data;
        if (adv && r_in_item.last_byte)
            r_out_data <= result;
    end

endmodule

>>> design/tsni_checker.sv
`timescale 1ns / 1ps

module tsni_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input tsni_pkg::t_out_item o_out_data
);
    import tsni_pkg::*;

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("result changed while stalled");

    a_split_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.split_position != 14'd0
            && 15'(o_out_data.split_position) <= o_out_data.packet_length)
        else $error("split point outside packet");

    a_sni_needs_tls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.sni_found |-> o_out_data.tls_hello_seen)
        else $error("sni reported without client hello");

    a_overlong_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.overlong |-> o_out_data.packet_length == 15'(MAX_PACKET))
        else $error("overlong with short length");

endmodule

bind tls_sni_locator_and_split_point_core tsni_checker u_tsni_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
